FILE: hw/rtl/nnis_pkg.sv
// ---------------------------------------------------------------------------
// nnis_pkg
// Types, register indexes and helpers shared by the nearest-neighbor scaler.
// ---------------------------------------------------------------------------
package nnis_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 128;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned SIZE_W    = 8;
  localparam int unsigned BPP_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;

  // request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_data;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             image_end;
  } out_item_t;

  function automatic logic [PIX_W-1:0] byte_mask(logic [BPP_W-1:0] bpp);
    logic [PIX_W-1:0] m;
    unique case (bpp)
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/nnis_ram.sv
// ---------------------------------------------------------------------------
// nnis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module nnis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/nnis_div.sv
// ---------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle, for quotients below 2**QW.
// ---------------------------------------------------------------------------
module nnis_div #(
  parameter int unsigned NW = 15,
  parameter int unsigned QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [QW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int unsigned TW = NW + QW;
  localparam int unsigned SW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0] rem_r;
  logic [QW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic [SW-1:0] step_r;
  logic          run_r;
  logic          done_r;

  logic [TW-1:0] trial;
  logic          fits;

  assign trial = TW'(den_r) << step_r;
  assign fits  = TW'(rem_r) >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        den_r  <= den;
        q_r    <= '0;
        step_r <= SW'(QW - 1);
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (fits) begin
          rem_r        <= NW'(TW'(rem_r) - trial);
          q_r[step_r]  <= 1'b1;
        end
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hw/rtl/nearest_neighbor_image_scaler.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor rescaler around a frame store of source pixels.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low.
//   in_data.mode selects a load (write the next source pixel in raster
//   order) or a fetch (return the next destination pixel in raster order).
//   Loads give no result; busy stays low.
//   A fetch raises busy; the result appears on out_data with out_valid
//   high for one cycle, and busy falls in that same cycle. The path
//   runs through the multiply state, the two 8-step row/column dividers
//   that run side by side, the registered divider done flag, one
//   frame-store read and one output register.
//   The receiver has no way to stall; out_valid is a plain strobe.
//   Configuration is a write-only register file (cfg_we, cfg_idx,
//   cfg_wdata), to be written only while busy is low.
//   Reset sets all sizes and the byte count to 1 and the load and fetch
//   positions to zero; frame store contents stay undefined until loaded.
// ---------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
  parameter int unsigned MAX_WIDTH  = nnis_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nnis_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  nnis_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output nnis_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [nnis_pkg::SIZE_W-1:0]         cfg_wdata
);

  localparam int unsigned SZ    = nnis_pkg::SIZE_W;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned NXW   = CW + SZ;
  localparam int unsigned NYW   = RW + SZ;
  localparam int unsigned CMPW  = ((CW > RW) ? CW : RW) + SZ;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_READ, S_DATA} state_t;

  function automatic logic [SZ-1:0] clamp_size(logic [SZ-1:0] v, int unsigned maxv);
    logic [SZ-1:0] r;
    if (v == '0) begin
      r = SZ'(1);
    end else if (32'(v) > maxv) begin
      r = SZ'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  logic [SZ-1:0]                  src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [nnis_pkg::BPP_W-1:0]     bpp_r;
  logic [nnis_pkg::BPP_W-1:0]     bpp_wr;

  assign bpp_wr = (cfg_wdata[2:0] >= 3'd1 && cfg_wdata[2:0] <= 3'd4) ?
                  cfg_wdata[2:0] : 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SZ'(1);
      src_h_r <= SZ'(1);
      dst_w_r <= SZ'(1);
      dst_h_r <= SZ'(1);
      bpp_r   <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        nnis_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        nnis_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        nnis_pkg::REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        nnis_pkg::REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        nnis_pkg::REG_BPP:        bpp_r   <= bpp_wr;
        default: ;
      endcase
    end
  end

  logic [SZ-1:0]              sw, sh, dw, dh;
  logic [nnis_pkg::PIX_W-1:0] mask;

  assign sw   = clamp_size(src_w_r, MAX_WIDTH);
  assign sh   = clamp_size(src_h_r, MAX_HEIGHT);
  assign dw   = clamp_size(dst_w_r, MAX_WIDTH);
  assign dh   = clamp_size(dst_h_r, MAX_HEIGHT);
  assign mask = nnis_pkg::byte_mask(bpp_r);

  // control state
  state_t                     state_r;
  logic [AW-1:0]              li_r;
  logic [RW-1:0]              row_r;
  logic [CW-1:0]              col_r;
  logic                       out_valid_r;
  nnis_pkg::out_item_t        out_data_r;

  logic accept, load_acc, fetch_acc;
  assign accept    = start && (state_r == S_IDLE);
  assign load_acc  = accept && (in_data.mode == nnis_pkg::MODE_LOAD);
  assign fetch_acc = accept && (in_data.mode == nnis_pkg::MODE_FETCH);

  // load address: restart when the image size shrank under the position
  logic [31:0]   count;
  logic [AW-1:0] li_eff;
  logic [31:0]   li_inc;
  logic [AW-1:0] li_nxt;

  assign count  = 32'(sw) * 32'(sh);
  assign li_eff = (32'(li_r) >= count) ? '0 : li_r;
  assign li_inc = 32'(li_eff) + 32'd1;
  assign li_nxt = (li_inc >= count) ? '0 : AW'(li_inc);

  // fetch position with wrap for a shrunk destination size
  logic [RW-1:0] row_eff;
  logic [CW-1:0] col_eff;
  assign row_eff = (CMPW'(row_r) >= CMPW'(dh)) ? '0 : row_r;
  assign col_eff = (CMPW'(col_r) >= CMPW'(dw)) ? '0 : col_r;

  logic rend, iend;
  assign rend = CMPW'(col_r) == CMPW'(dw) - CMPW'(1);
  assign iend = rend && (CMPW'(row_r) == CMPW'(dh) - CMPW'(1));

  // scaled source coordinates
  logic          div_start;
  logic          div_done_x, div_done_y;
  logic [SZ-1:0] qx, qy;
  logic [NXW-1:0] num_x;
  logic [NYW-1:0] num_y;

  assign div_start = (state_r == S_MUL);
  assign num_x     = NXW'(col_r) * NXW'(sw);
  assign num_y     = NYW'(row_r) * NYW'(sh);

  nnis_div #(.NW(NXW), .QW(SZ)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x),
    .den   (dw),
    .done  (div_done_x),
    .quot  (qx)
  );

  nnis_div #(.NW(NYW), .QW(SZ)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y),
    .den   (dh),
    .done  (div_done_y),
    .quot  (qy)
  );

  // frame store
  logic [2*SZ:0]               raddr_full;
  logic [AW-1:0]               raddr;
  logic [nnis_pkg::PIX_W-1:0]  rdata;

  assign raddr_full = {{(SZ+1){1'b0}}, qy} * {{(SZ+1){1'b0}}, sw} +
                      {{(SZ+1){1'b0}}, qx};
  assign raddr      = AW'(raddr_full);

  nnis_ram #(.WIDTH(nnis_pkg::PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (li_eff),
    .wdata (in_data.pixel_data & mask),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      li_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (load_acc) begin
            li_r <= li_nxt;
          end else if (fetch_acc) begin
            row_r   <= row_eff;
            col_r   <= col_eff;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done_y) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_DATA;
        end
        S_DATA: begin
          out_valid_r          <= 1'b1;
          out_data_r.pixel_out <= rdata & mask;
          out_data_r.row_end   <= rend;
          out_data_r.image_end <= iend;
          if (rend) begin
            col_r <= '0;
            row_r <= iend ? '0 : RW'(row_r + 1'b1);
          end else begin
            col_r <= CW'(col_r + 1'b1);
          end
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_acc |=> busy) else $error("fetch request did not raise busy");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !busy) else $error("load request left the block busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_end |-> out_data.row_end)
    else $error("image end without row end");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_x == div_done_y) else $error("row and column dividers out of step");
`endif

endmodule
